>>> sv/assert_macros.svh
// Assertion macros for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define U8_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("u8u16 check failed");

// Checked at every edge, also while reset is held.
`define U8_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("u8u16 check failed during reset");

`endif

>>> sv/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

	typedef logic [15:0] unit_t;
	typedef logic [1:0] seq_len_t;

	// Expected sequence length minus one; zero means nothing pending.
	localparam seq_len_t LEN_NONE  = 2'd0;
	localparam seq_len_t LEN_TWO   = 2'd1;
	localparam seq_len_t LEN_THREE = 2'd2;
	localparam seq_len_t LEN_FOUR  = 2'd3;

	localparam int unsigned MAX_UNITS = 4;

	localparam unit_t       REJECT_UNIT    = 16'h003F;
	localparam unit_t       HIGH_SURR_BASE = 16'hD800;
	localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;
	localparam logic [25:0] SUPP_OFFSET    = 26'h001_0000;

endpackage

>>> sv/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-16 decoder.
// Input channel: one UTF-8 byte per transfer on data_byte, handshake
// byte_valid / byte_stall. A zero byte ends the text and flushes any pending
// sequence without a unit of its own.
// Output channel: one UTF-16 code unit per transfer on code_unit, handshake
// unit_valid / unit_stall; last_of_run marks the final unit caused by a byte.
// A byte causes zero to four units (rejected bytes come out as 0x003F).
// A byte's units pass through the result buffer, then the output register.
// Throughput: one byte per cycle while each byte gives at most one unit and
// the receiver does not stall. A byte's decoded units sit in a four-entry
// result buffer that drains one unit per cycle, unless stalled, into the
// output register; the input reopens as the last of them moves there.
// While the receiver stalls, the output register holds its unit and the result
// buffer fills; byte_stall rises once the buffer cannot take the next byte.
// Reset clears the pending sequence, the result buffer and the output valid;
// the block accepts a byte in the first cycle after reset.
module utf8_to_utf16_decoder
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	output logic        unit_valid,
	input  logic        unit_stall,
	output logic [15:0] code_unit,
	output logic        last_of_run
);

	localparam int unsigned CNT_W = $clog2(MAX_UNITS + 1);

	// Pending sequence state.
	seq_len_t     plen_q, plen_d;
	logic [1:0]   pcnt_q, pcnt_d;
	logic [20:0]  bits_q, bits_d;

	// Result buffer of the byte in flight.
	unit_t              units_s1 [MAX_UNITS];
	logic [CNT_W-1:0]   rem_s1;

	// Output register.
	logic   unit_valid_q;
	unit_t  code_unit_q;
	logic   last_q;

	logic               accept;
	logic               out_load;
	logic [1:0]         rej_cnt;
	logic [1:0]         tail_cnt;
	unit_t              tail0, tail1;
	logic [20:0]        cont_bits;
	logic [25:0]        supp;
	logic [CNT_W-1:0]   new_cnt;
	unit_t              new_units [MAX_UNITS];

	assign out_load   = (rem_s1 != '0) && (!unit_valid_q || !unit_stall);
	assign byte_stall = !((rem_s1 == '0) || ((rem_s1 == CNT_W'(1)) && out_load));
	assign accept     = byte_valid && !byte_stall;

	assign cont_bits = {bits_q[14:0], data_byte[5:0]};
	assign supp      = 26'(cont_bits) - SUPP_OFFSET;

	always_comb begin
		rej_cnt  = 2'd0;
		tail_cnt = 2'd0;
		tail0    = REJECT_UNIT;
		tail1    = REJECT_UNIT;
		plen_d   = plen_q;
		pcnt_d   = pcnt_q;
		bits_d   = bits_q;
		if ((plen_q != LEN_NONE) && (data_byte[7:6] == 2'b10)) begin
			bits_d = cont_bits;
			if (pcnt_q >= plen_q) begin
				if (plen_q == LEN_FOUR) begin
					tail_cnt = 2'd2;
					tail0    = supp[25:10] + HIGH_SURR_BASE;
					tail1    = {LOW_SURR_TAG, supp[9:0]};
				end else begin
					tail_cnt = 2'd1;
					tail0    = cont_bits[15:0];
				end
				plen_d = LEN_NONE;
				pcnt_d = 2'd0;
				bits_d = '0;
			end else begin
				pcnt_d = pcnt_q + 2'd1;
			end
		end else begin
			// A broken sequence rejects every buffered byte, then the byte is a lead.
			rej_cnt = (plen_q != LEN_NONE) ? pcnt_q : 2'd0;
			plen_d  = LEN_NONE;
			pcnt_d  = 2'd0;
			bits_d  = '0;
			if (data_byte == 8'h00) begin
				tail_cnt = 2'd0;
			end else if (!data_byte[7]) begin
				tail_cnt = 2'd1;
				tail0    = {8'h00, data_byte};
			end else if (data_byte[7:5] == 3'b110) begin
				plen_d = LEN_TWO;
				pcnt_d = 2'd1;
				bits_d = {16'h0000, data_byte[4:0]};
			end else if (data_byte[7:4] == 4'b1110) begin
				plen_d = LEN_THREE;
				pcnt_d = 2'd1;
				bits_d = {17'h00000, data_byte[3:0]};
			end else if (data_byte[7:3] == 5'b11110) begin
				plen_d = LEN_FOUR;
				pcnt_d = 2'd1;
				bits_d = {18'h00000, data_byte[2:0]};
			end else begin
				tail_cnt = 2'd1;
				tail0    = REJECT_UNIT;
			end
		end
	end

	assign new_cnt = CNT_W'(rej_cnt) + CNT_W'(tail_cnt);

	always_comb begin
		for (int i = 0; i < MAX_UNITS; i++) begin
			if (CNT_W'(i) < CNT_W'(rej_cnt)) begin
				new_units[i] = REJECT_UNIT;
			end else if (CNT_W'(i) == CNT_W'(rej_cnt)) begin
				new_units[i] = tail0;
			end else begin
				new_units[i] = tail1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= LEN_NONE;
			pcnt_q <= 2'd0;
			bits_q <= '0;
		end else if (accept) begin
			plen_q <= plen_d;
			pcnt_q <= pcnt_d;
			bits_q <= bits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s1 <= '0;
		end else if (accept) begin
			rem_s1 <= new_cnt;
		end else if (out_load) begin
			rem_s1 <= rem_s1 - CNT_W'(1);
		end
	end

	// The head of the buffer always feeds the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			units_s1 <= new_units;
		end else if (out_load) begin
			for (int i = 0; i < MAX_UNITS - 1; i++) begin
				units_s1[i] <= units_s1[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid_q <= 1'b0;
		end else if (out_load) begin
			unit_valid_q <= 1'b1;
		end else if (!unit_stall) begin
			unit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			code_unit_q <= units_s1[0];
			last_q      <= (rem_s1 == CNT_W'(1));
		end
	end

	assign unit_valid  = unit_valid_q;
	assign code_unit   = code_unit_q;
	assign last_of_run = last_q;

endmodule

>>> sv/u8u16_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_stall,
	input logic [7:0]  data_byte,
	input logic        unit_valid,
	input logic        unit_stall,
	input logic [15:0] code_unit,
	input logic        last_of_run
);

	logic unit_xfer;
	logic unit_held;

	assign unit_xfer = unit_valid && !unit_stall;
	assign unit_held = unit_valid && unit_stall;

	// A stalled unit stays on the port unchanged.
	`U8_ASSERT(a_unit_hold, clk, arst_n, unit_held |=> unit_valid && $stable({code_unit, last_of_run}))

	// Once reset has been held over an edge, nothing is offered and the input is open.
	`U8_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n ##1 !arst_n |-> !unit_valid && !byte_stall)

	// The input only stalls while units are backed up, so a unit is offered next.
	`U8_ASSERT(a_stall_has_units, clk, arst_n, byte_stall |=> unit_valid)

	// The rest of a run follows its earlier unit in the next cycle.
	`U8_ASSERT(a_run_continues, clk, arst_n, unit_xfer && !last_of_run |=> unit_valid)

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_u8u16_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_stall  (byte_stall),
	.data_byte   (data_byte),
	.unit_valid  (unit_valid),
	.unit_stall  (unit_stall),
	.code_unit   (code_unit),
	.last_of_run (last_of_run)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import u8u16_pkg::*;

	localparam logic [7:0] TEXT_END = 8'h00;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		unit_t unit;
		logic  last;
	} unit_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        unit_valid;
	logic        unit_stall = 1'b0;
	logic [15:0] code_unit;
	logic        last_of_run;

	// Decoder state as seen by the prediction side.
	seq_len_t    pend_len = LEN_NONE;
	logic [1:0]  pend_cnt = 2'd0;
	logic [20:0] code_acc = 21'd0;

	logic [7:0]  pending_bytes[$];
	unit_t       run_units[$];
	unit_rec_t   expected_units[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_count = 0;

	logic [7:0] directed_text [24] = '{
		8'h00, 8'h7F, 8'h80, 8'hFF,
		8'hC2, 8'hA9,
		8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h80, 8'h80, 8'h80,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hF0, 8'h90, 8'h80, 8'hF8,
		8'hE2, 8'h82, 8'h00
	};

	utf8_to_utf16_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.unit_valid  (unit_valid),
		.unit_stall  (unit_stall),
		.code_unit   (code_unit),
		.last_of_run (last_of_run)
	);

	always #4 clk = ~clk;

	task automatic start_sequence(input logic [7:0] b);
		pend_len = LEN_NONE;
		pend_cnt = 2'd0;
		code_acc = 21'd0;
		if (b == TEXT_END) begin
			// The terminator leaves nothing pending and gives no unit.
		end else if (b[7] == 1'b0) begin
			run_units.push_back({8'h00, b});
		end else if (b[7:5] == 3'b110) begin
			pend_len = LEN_TWO;
			pend_cnt = 2'd1;
			code_acc = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			pend_len = LEN_THREE;
			pend_cnt = 2'd1;
			code_acc = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			pend_len = LEN_FOUR;
			pend_cnt = 2'd1;
			code_acc = {18'd0, b[2:0]};
		end else begin
			run_units.push_back(REJECT_UNIT);
		end
	endtask

	// Works out the code units one accepted byte gives and queues them.
	task automatic decode_byte(input logic [7:0] b);
		logic [31:0] offset;
		run_units.delete();
		if (pend_len != LEN_NONE) begin
			if (b[7:6] == 2'b10) begin
				code_acc = {code_acc[14:0], b[5:0]};
				if (pend_cnt >= pend_len) begin
					if (pend_len == LEN_FOUR) begin
						// Values below 0x10000 wrap here and are cut to 16 bits.
						offset = {11'd0, code_acc} - 32'h0001_0000;
						run_units.push_back(unit_t'((offset >> 10) + HIGH_SURR_BASE));
						run_units.push_back({LOW_SURR_TAG, offset[9:0]});
					end else begin
						run_units.push_back(code_acc[15:0]);
					end
					pend_len = LEN_NONE;
					pend_cnt = 2'd0;
					code_acc = 21'd0;
				end else begin
					pend_cnt = pend_cnt + 2'd1;
				end
			end else begin
				// A broken sequence rejects every buffered byte, then the
				// breaking byte starts over as a lead.
				for (int k = 0; k < pend_cnt; k++)
					run_units.push_back(REJECT_UNIT);
				start_sequence(b);
			end
		end else begin
			start_sequence(b);
		end
		foreach (run_units[i])
			expected_units.push_back('{unit: run_units[i], last: (i == run_units.size() - 1)});
	endtask

	function automatic logic [7:0] lead_byte(input int extra);
		case (extra)
			1:       lead_byte = {3'b110, 5'($urandom)};
			2:       lead_byte = {4'b1110, 4'($urandom)};
			default: lead_byte = {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// Mostly well-formed sequences with random content, some truncated ones
	// and some raw noise.
	task automatic gen_text(input int count);
		int made;
		int kind;
		int extra;
		int conts;
		logic [7:0] b;
		made = 0;
		while (made < count) begin
			kind = $urandom_range(99);
			if (kind < 25) begin
				pending_bytes.push_back(8'($urandom_range(1, 127)));
				made++;
			end else if (kind < 80) begin
				extra = (kind < 45) ? 1 : (kind < 65) ? 2 : 3;
				pending_bytes.push_back(lead_byte(extra));
				for (int k = 0; k < extra; k++)
					pending_bytes.push_back({2'b10, 6'($urandom)});
				made += extra + 1;
			end else if (kind < 92) begin
				extra = $urandom_range(1, 3);
				conts = $urandom_range(0, extra - 1);
				pending_bytes.push_back(lead_byte(extra));
				for (int k = 0; k < conts; k++)
					pending_bytes.push_back({2'b10, 6'($urandom)});
				b = 8'($urandom);
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				if ($urandom_range(3) == 0)
					b = TEXT_END;
				pending_bytes.push_back(b);
				made += conts + 2;
			end else begin
				pending_bytes.push_back(8'($urandom));
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || byte_valid || expected_units.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte <= 8'h00;
		end else begin
			if (byte_valid && !byte_stall)
				decode_byte(data_byte);
			if (!byte_valid || !byte_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_valid <= 1'b1;
					data_byte <= pending_bytes.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		unit_rec_t want;
		if (!arst_n) begin
			unit_stall <= 1'b0;
		end else begin
			if (unit_valid && !unit_stall) begin
				if (expected_units.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected unit transfer: code_unit=%h last_of_run=%b",
							code_unit, last_of_run);
				end else begin
					want = expected_units.pop_front();
					if (code_unit !== want.unit || last_of_run !== want.last) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("unit mismatch: expected %h/%b, got %h/%b",
								want.unit, want.last, code_unit, last_of_run);
					end
				end
			end
			unit_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 37;
		recv_idle_pct = 63;
		foreach (directed_text[i])
			pending_bytes.push_back(directed_text[i]);
		gen_text(130);
		// Wait until every queued byte is sent and every expected unit has arrived.
		wait_drained();

		send_idle_pct = 63;
		recv_idle_pct = 37;
		gen_text(140);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		gen_text(140);
		wait_drained();

		repeat (16) @(negedge clk);
		if (fail_count == 0 && expected_units.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
